// ===== hw/rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg - shared definitions for the life generation stencil
// Grid limits, field widths, rule counts, register indexes and the edge
// flag bundle passed from the position tracker to the cell evaluator.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);    // line store address
  localparam int WID_W  = COL_W + 1;            // holds MAX_WIDTH itself
  localparam int ROW_W  = 11;                   // row position, saturates
  localparam int CFG_W  = 11;                   // grid_width / grid_height
  localparam int EMIT_W = 20;                   // cells emitted in a frame
  localparam int CNT_W  = 4;                    // neighbour count 0..8
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [CNT_W-1:0] STAY_COUNT  = 4'd2;

  // window layout: bits 0..2 two rows back, 3..5 one row back, 6..8 current
  localparam logic [8:0] WIN_SHIFT_MASK = 9'h1B6;
  localparam logic [8:0] CENTRE_BIT     = 9'h010;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic top_row;     // emitted cell lies in the first row
    logic bottom_row;  // emitted cell lies in the last row
    logic left_col;    // emitted cell lies in the first column
    logic right_col;   // emitted cell lies in the last column
  } lgs_edges_t;

endpackage

// ===== hw/rtl/life_generation_stencil_core.sv =====
// ----------------------------------------------------------------------------
// life_generation_stencil_core - one generation of B3/S23 over a cell stream
// Two line stores and a 3x3 window evaluate each cell as its lower row
// arrives; borders count as dead.
// ----------------------------------------------------------------------------
// Usage:
//   Cells enter in raster order on the in_ channel, one per transaction; an
//   item with in_flush high counts as a dead cell. After the W*H cells of a
//   frame, send W+1 flush items to push out the last row.
//   Each transaction that completes a cell gives one out_ transaction, lagging
//   the stream by one row plus one cell; the first W+1 items of a frame give
//   none. out_last_cell marks the final cell, after which a new frame starts.
//   One item is taken every cycle while in_stall is low; it is registered in
//   the item stage, and its result is registered when the item leaves that
//   stage and then shows on out_. The line stores have one read and one
//   write port, read at the accept edge and written when the item leaves
//   the item stage, with a bypass for back-to-back use of the same column.
//   A stall on out_ holds the result register and the item stage, and in_stall
//   rises only once both are full.
//   After reset, in_stall stays high while all MAX_WIDTH (1024) entries of
//   both line stores are cleared; register writes are taken throughout.
//   grid_width and grid_height: APB byte addresses 0 and 4 (decoded on paddr[2]).
//   A write restarts the frame; the user must make it while idle (not enforced).
// ----------------------------------------------------------------------------
module life_generation_stencil_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cell_alive,
  input  logic                       in_flush,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_next_alive,
  output logic [lgs_pkg::CNT_W-1:0]  out_neighbour_count,
  output logic                       out_last_cell,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lgs_pkg::ADDR_W-1:0] paddr,
  input  logic [lgs_pkg::DATA_W-1:0] pwdata,
  output logic [lgs_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import lgs_pkg::*;

  // configuration
  logic [CFG_W-1:0] grid_width_r, grid_width_nxt;
  logic [CFG_W-1:0] grid_height_r, grid_height_nxt;
  logic             cfg_wr;
  logic [WID_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;

  // line store clearing
  logic             clr_active_r, clr_active_nxt;
  logic [COL_W-1:0] clr_addr_r, clr_addr_nxt;

  // frame position
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [EMIT_W-1:0] emit_cnt_r, emit_cnt_nxt;

  // position decode for the incoming item
  logic             x_zero;
  logic             emit_ok;
  logic [ROW_W-1:0] pr;
  logic             produce;
  logic             last;
  lgs_edges_t       edges;
  logic [WID_W-1:0] col_inc;
  logic             cell_in;

  // item stage
  logic             a_valid_r, a_valid_nxt;
  logic             a_cell_r;
  logic [COL_W-1:0] a_col_r;
  logic             a_produce_r;
  logic             a_last_r;
  lgs_edges_t       a_edges_r;
  logic             hit_r;
  logic             fwd_top_r;
  logic             fwd_mid_r;
  logic             up_rd_r;
  logic             mid_rd_r;

  // line stores
  logic             upper_mem [MAX_WIDTH];
  logic             middle_mem [MAX_WIDTH];
  logic             mem_we;
  logic [COL_W-1:0] mem_addr;
  logic             up_wd;
  logic             mid_wd;

  // window and evaluation
  logic [8:0]       win_r, win_nxt;
  logic             top_in;
  logic             mid_in;
  logic [CNT_W-1:0] eval_count;
  logic             eval_alive;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic             out_alive_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_last_r;

  logic             in_acc;
  logic             advance;
  logic             hit;

  // ------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_GRID_WIDTH:  grid_width_nxt  = pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: grid_height_nxt = pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_WIDTH:  prdata = DATA_W'(grid_width_r);
      REG_GRID_HEIGHT: prdata = DATA_W'(grid_height_r);
    endcase
  end

  // out-of-range sizes are clamped
  always_comb begin
    if (grid_width_r == '0) begin
      eff_w = WID_W'(1);
    end else if (int'(grid_width_r) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(grid_width_r);
    end
  end

  always_comb begin
    if (grid_height_r == '0) begin
      eff_h = ROW_W'(1);
    end else if (int'(grid_height_r) > MAX_HEIGHT) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_h = ROW_W'(grid_height_r);
    end
  end

  // ------------------------------------------------------------------
  // handshake
  // ------------------------------------------------------------------
  assign advance  = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_active_r || (a_valid_r && !advance);
  assign in_acc   = in_valid && !in_stall;
  assign hit      = advance && (a_col_r == col_r);
  assign cell_in  = in_cell_alive && !in_flush;

  // ------------------------------------------------------------------
  // position of the cell that the incoming item completes
  // ------------------------------------------------------------------
  assign x_zero = (col_r == '0);

  always_comb begin
    if (!x_zero) begin
      emit_ok = (row_r >= ROW_W'(1));
      pr      = row_r - ROW_W'(1);
    end else begin
      // start of a row finishes the last cell of the row two back
      emit_ok = (row_r >= ROW_W'(2));
      pr      = row_r - ROW_W'(2);
    end
  end

  assign produce          = emit_ok && (pr < eff_h);
  assign edges.top_row    = (pr == '0);
  assign edges.bottom_row = (pr == eff_h - ROW_W'(1));
  assign edges.left_col   = x_zero ? (eff_w == WID_W'(1)) : (col_r == COL_W'(1));
  assign edges.right_col  = x_zero;
  assign last             = edges.bottom_row && edges.right_col;
  assign col_inc          = {1'b0, col_r} + WID_W'(1);

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    emit_cnt_nxt = emit_cnt_r;
    if (cfg_wr) begin
      col_nxt      = '0;
      row_nxt      = '0;
      emit_cnt_nxt = '0;
    end else if (in_acc) begin
      if (produce && last) begin
        col_nxt      = '0;
        row_nxt      = '0;
        emit_cnt_nxt = '0;
      end else begin
        if (produce) begin
          emit_cnt_nxt = emit_cnt_r + EMIT_W'(1);
        end
        if (col_inc >= eff_w) begin
          col_nxt = '0;
          if (row_r != '1) begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          col_nxt = col_inc[COL_W-1:0];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // clearing pass and stage control
  // ------------------------------------------------------------------
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + COL_W'(1);
      if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      a_valid_nxt = 1'b1;
    end else if (advance) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = a_produce_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= CFG_W'(64);
      grid_height_r <= CFG_W'(64);
      clr_active_r  <= 1'b1;
      clr_addr_r    <= '0;
      col_r         <= '0;
      row_r         <= '0;
      emit_cnt_r    <= '0;
      a_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      win_r         <= '0;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      clr_active_r  <= clr_active_nxt;
      clr_addr_r    <= clr_addr_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      emit_cnt_r    <= emit_cnt_nxt;
      a_valid_r     <= a_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      win_r         <= win_nxt;
    end
  end

  // item stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_cell_r    <= cell_in;
      a_col_r     <= col_r;
      a_produce_r <= produce;
      a_last_r    <= last;
      a_edges_r   <= edges;
      // the store write of the leaving item lands on the same edge
      hit_r       <= hit;
      fwd_top_r   <= mid_in;
      fwd_mid_r   <= a_cell_r;
    end
  end

  // ------------------------------------------------------------------
  // line stores
  // ------------------------------------------------------------------
  assign mem_we   = clr_active_r || advance;
  assign mem_addr = clr_active_r ? clr_addr_r : a_col_r;
  assign up_wd    = clr_active_r ? 1'b0 : mid_in;
  assign mid_wd   = clr_active_r ? 1'b0 : a_cell_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      upper_mem[mem_addr] <= up_wd;
    end
    if (in_acc) begin
      up_rd_r <= upper_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      middle_mem[mem_addr] <= mid_wd;
    end
    if (in_acc) begin
      mid_rd_r <= middle_mem[col_r];
    end
  end

  // ------------------------------------------------------------------
  // window and evaluation
  // ------------------------------------------------------------------
  assign top_in = hit_r ? fwd_top_r : up_rd_r;
  assign mid_in = hit_r ? fwd_mid_r : mid_rd_r;

  always_comb begin
    win_nxt = win_r;
    if (advance) begin
      win_nxt = ((win_r << 1) & WIN_SHIFT_MASK)
              | {2'b00, a_cell_r, 2'b00, mid_in, 2'b00, top_in};
    end
  end

  lgs_cell_eval u_cell_eval (
    .win             (win_nxt),
    .edges           (a_edges_r),
    .neighbour_count (eval_count),
    .next_alive      (eval_alive)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      out_alive_r <= eval_alive;
      out_count_r <= eval_count;
      out_last_r  <= a_last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_next_alive      = out_alive_r;
  assign out_neighbour_count = out_count_r;
  assign out_last_cell       = out_last_r;

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (in_stall && !a_valid_r))
    else $error("item taken during line store clearing");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < eff_w)
    else $error("column position beyond grid width");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && produce && last) |=> (col_r == '0 && row_r == '0 && emit_cnt_r == '0))
    else $error("frame did not restart after final cell");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r <= CNT_W'(8)))
    else $error("neighbour count above eight");
`endif

endmodule

// ===== hw/rtl/lgs_cell_eval.sv =====
// ----------------------------------------------------------------------------
// lgs_cell_eval - neighbour count and B3/S23 rule
// Masks the 3x3 window at the grid borders, counts the live neighbours and
// decides the next state of the centre cell.
// ----------------------------------------------------------------------------
module lgs_cell_eval (
  input  logic [8:0]                win,
  input  lgs_pkg::lgs_edges_t       edges,
  output logic [lgs_pkg::CNT_W-1:0] neighbour_count,
  output logic                      next_alive
);
  import lgs_pkg::*;

  logic [8:0]       row_keep;
  logic [2:0]       col_keep;
  logic [8:0]       keep;
  logic [8:0]       live;
  logic [CNT_W-1:0] sum;

  // tap 0 is the newest column (right of centre), tap 2 the oldest (left)
  assign row_keep = {{3{~edges.bottom_row}}, 3'b111, {3{~edges.top_row}}};
  assign col_keep = {~edges.left_col, 1'b1, ~edges.right_col};
  assign keep     = row_keep & {3{col_keep}} & ~CENTRE_BIT;
  assign live     = win & keep;

  always_comb begin
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      sum = sum + CNT_W'(live[i]);
    end
  end

  assign neighbour_count = sum;
  assign next_alive = (sum == BIRTH_COUNT) || (win[4] && (sum == STAY_COUNT));

endmodule
